>>> sv/connection_timeout_table_defines.svh
// assertion macros for the connection timeout table
`ifndef CONNECTION_TIMEOUT_TABLE_DEFINES_SVH
`define CONNECTION_TIMEOUT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clock edge outside reset
`define CTT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection timeout table check failed");
// next-cycle implication
`define CTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection timeout table check failed");
`else
`define CTT_ASSERT_NOW(label, ante, cons)
`define CTT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/ctt_pkg.sv
// shared types and constants of the connection timeout table
package ctt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TICK_MS    = 100;

	localparam int ID_W    = 16;
	localparam int DELAY_W = 32;
	localparam int REM_W   = 26;
	localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [REM_W-1:0] REMAIN_MAX = {REM_W{1'b1}};

	// delay / TICK_MS as a multiply by a rounded-up reciprocal and a shift
	localparam int DIV_SHIFT = DELAY_W + $clog2(TICK_MS);
	localparam logic [63:0] DIV_MULT =
		((64'd1 << DIV_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
	localparam logic [15:0] DIV_M_LO = DIV_MULT[15:0];
	localparam logic [16:0] DIV_M_HI = DIV_MULT[32:16];
	localparam int PLO_W = DELAY_W + 16;
	localparam int PHI_W = DELAY_W + 17;
	localparam int SUM_W = DELAY_W + 34;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	localparam logic KIND_SET    = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic             active;
		logic [ID_W-1:0]  conn;
		logic [REM_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		logic            strobe;
		logic            kind;
		logic            status;
		logic [ID_W-1:0] expired_id;
		logic            last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_TICK,
		ST_FLUSH
	} state_t;

endpackage

>>> sv/ctt_cell.sv
// one timer cell of the rotating entry ring
module ctt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  ctt_pkg::entry_t d,
	output ctt_pkg::entry_t q
);
	import ctt_pkg::*;

	logic             active_q;
	logic [ID_W-1:0]  conn_q;
	logic [REM_W-1:0] remaining_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift_en) begin
			active_q <= d.active;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			conn_q      <= d.conn;
			remaining_q <= d.remaining;
		end
	end

	assign q = '{active: active_q, conn: conn_q, remaining: remaining_q};

endmodule

>>> sv/ctt_ctrl.sv
// sequencer and head-of-ring processing for the timer table
module ctt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      operation,
	input  logic [ctt_pkg::ID_W-1:0]  conn_id,
	input  logic [ctt_pkg::DELAY_W-1:0] delay_ms,
	input  ctt_pkg::entry_t           head,
	output ctt_pkg::entry_t           ring_in,
	output logic                      shift_en,
	output logic                      busy,
	output ctt_pkg::res_t             res
);
	import ctt_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             pass_end;
	logic             accept;

	logic [ID_W-1:0]  id_q;
	logic [PLO_W-1:0] plo_q;
	logic [PHI_W-1:0] phi_q;

	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [IDX_W-1:0] tgt_idx;
	logic             do_write;

	logic             pend_v_q;
	logic [ID_W-1:0]  pend_id_q;

	logic             res_strobe_q, res_kind_q, res_status_q, res_last_q;
	logic [ID_W-1:0]  res_id_q;

	logic [SUM_W-1:0] prod_sum;
	logic [SUM_W-1:0] quot;
	logic [REM_W-1:0] load_val;

	logic hit_now, free_now, expire_now;

	assign pass_end = (cnt_q == IDX_W'(NUM_TIMERS - 1));
	assign accept   = start && (state_q == ST_IDLE);

	// load value: quotient clamped to 1 .. REMAIN_MAX
	assign prod_sum = SUM_W'({phi_q, 16'b0}) + SUM_W'(plo_q);
	assign quot     = prod_sum >> DIV_SHIFT;
	always_comb begin
		if (quot == '0) begin
			load_val = REM_W'(1);
		end else if (quot > SUM_W'(REMAIN_MAX)) begin
			load_val = REMAIN_MAX;
		end else begin
			load_val = quot[REM_W-1:0];
		end
	end

	assign hit_now    = head.active && (head.conn == id_q);
	assign free_now   = !head.active;
	assign expire_now = head.active && (head.remaining <= REM_W'(1));
	assign tgt_idx    = hit_q ? hit_idx_q : free_idx_q;
	assign do_write   = (hit_q || free_q) && (cnt_q == tgt_idx);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_SET) ? ST_SCAN : ST_TICK;
				end
			end
			ST_SCAN: begin
				if (pass_end) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (pass_end) state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (pass_end) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		shift_en = 1'b0;
		ring_in  = head;
		busy     = (state_q != ST_IDLE);
		case (state_q)
			ST_SCAN: begin
				shift_en = 1'b1;
			end
			ST_WRITE: begin
				shift_en = 1'b1;
				if (do_write) begin
					ring_in = '{active: 1'b1, conn: id_q, remaining: load_val};
				end
			end
			ST_TICK: begin
				shift_en = 1'b1;
				if (head.active) begin
					if (expire_now) begin
						ring_in.active    = 1'b0;
						ring_in.remaining = '0;
					end else begin
						ring_in.remaining = head.remaining - REM_W'(1);
					end
				end
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			pend_v_q     <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			// set answer at the end of the write pass, each expiry once the next one is found,
			// the held-back final expiry in the flush cycle
			res_strobe_q <= ((state_q == ST_WRITE) && pass_end)
				|| ((state_q == ST_TICK) && expire_now && pend_v_q)
				|| ((state_q == ST_FLUSH) && pend_v_q);
			if (accept) begin
				cnt_q    <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (shift_en) begin
				cnt_q <= pass_end ? '0 : cnt_q + IDX_W'(1);
			end
			if (state_q == ST_SCAN) begin
				if (hit_now && !hit_q) hit_q <= 1'b1;
				if (free_now && !free_q) free_q <= 1'b1;
			end
			if (state_q == ST_TICK) begin
				if (expire_now) begin
					pend_v_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= conn_id;
			plo_q <= PLO_W'(delay_ms) * PLO_W'(DIV_M_LO);
			phi_q <= PHI_W'(delay_ms) * PHI_W'(DIV_M_HI);
		end
		if (state_q == ST_SCAN) begin
			if (hit_now && !hit_q) hit_idx_q <= cnt_q;
			if (free_now && !free_q) free_idx_q <= cnt_q;
		end
		if (state_q == ST_WRITE && pass_end) begin
			res_kind_q   <= KIND_SET;
			res_status_q <= (hit_q || free_q) ? STATUS_OK : STATUS_FULL;
			res_id_q     <= '0;
			res_last_q   <= 1'b1;
		end
		if (state_q == ST_TICK && expire_now) begin
			pend_id_q    <= head.conn;
			res_kind_q   <= KIND_EXPIRY;
			res_status_q <= STATUS_OK;
			res_id_q     <= pend_id_q;
			res_last_q   <= 1'b0;
		end
		if (state_q == ST_FLUSH) begin
			res_kind_q   <= KIND_EXPIRY;
			res_status_q <= STATUS_OK;
			res_id_q     <= pend_id_q;
			res_last_q   <= 1'b1;
		end
	end

	assign res = '{strobe: res_strobe_q, kind: res_kind_q, status: res_status_q,
		expired_id: res_id_q, last: res_last_q};

endmodule

>>> sv/connection_timeout_table.sv
// top level of the connection timeout table
//
// usage:
//   input channel: a transaction is taken at a rising edge with start high and
//   busy low; operation selects a tick (0) or a set of conn_id with delay_ms (1)
//   result channel: each result sits on kind/status/expired_id/last for exactly
//   one cycle with strobe high; the receiver cannot stall it, so no backpressure
//   timing: the entries live in a ring of NUM_TIMERS cells that rotates one
//   place per cycle while an item is worked on; one full turn visits every entry
//   - set: one turn to look up the id or a free entry, one turn to write it;
//     busy falls and the answer strobes together as the write turn ends
//   - tick: one turn to count down, then a flush step; reports come in ascending
//     entry order, each held back until the next is found so the final one can
//     carry last; busy stays high through the flush step; quiet tick silent
//   the load value is delay_ms / TICK_MS clamped to 1 .. 2^26-1, computed by a
//   split reciprocal multiply registered at the accept edge
//   reset: all entries become free and the block is idle; no clearing pass
//
module connection_timeout_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [ctt_pkg::ID_W-1:0]      conn_id,
	input  logic [ctt_pkg::DELAY_W-1:0]   delay_ms,
	output logic                          strobe,
	output logic                          kind,
	output logic                          status,
	output logic [ctt_pkg::ID_W-1:0]      expired_id,
	output logic                          last
);
	import ctt_pkg::*;

	`include "connection_timeout_table_defines.svh"

	// cell k feeds cell k-1; cell 0 is the head seen by the sequencer,
	// whose processed entry re-enters at the far end of the ring
	entry_t cell_q [NUM_TIMERS];
	entry_t ring_in;
	logic   shift_en;
	res_t   res;

	for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
		entry_t cell_d;
		if (k == NUM_TIMERS - 1) begin : g_tail
			assign cell_d = ring_in;
		end else begin : g_mid
			assign cell_d = cell_q[k+1];
		end
		ctt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (cell_q[k])
		);
	end

	// sequencer: lookup, write and countdown passes plus result registers
	ctt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.conn_id   (conn_id),
		.delay_ms  (delay_ms),
		.head      (cell_q[0]),
		.ring_in   (ring_in),
		.shift_en  (shift_en),
		.busy      (busy),
		.res       (res)
	);

	assign strobe     = res.strobe;
	assign kind       = res.kind;
	assign status     = res.status;
	assign expired_id = res.expired_id;
	assign last       = res.last;

	// a set answer is a single result, so it always carries last
	`CTT_ASSERT_NOW(a_set_last, strobe && (kind == KIND_SET), last)
	// expiry reports never flag a full table
	`CTT_ASSERT_NOW(a_exp_ok, strobe && (kind == KIND_EXPIRY), status == STATUS_OK)
	// an accepted transaction keeps the block busy in the next cycle
	`CTT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
	// the set answer comes out as the block returns to idle
	`CTT_ASSERT_NOW(a_set_idle, strobe && (kind == KIND_SET), !busy)
	// the ring only rotates while a transaction is in progress
	`CTT_ASSERT_NOW(a_shift_busy, shift_en, busy)

endmodule
